// ===== hw/rtl/spline_waypoint_path_player_top_defines.svh =====
// assertion macros for the spline waypoint path player
`ifndef SPLINE_WAYPOINT_PATH_PLAYER_TOP_DEFINES_SVH
`define SPLINE_WAYPOINT_PATH_PLAYER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SWPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SWPP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWPP_ASSERT_IMP(label, ante, cons, msg)
`define SWPP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/swpp_pkg.sv =====
// shared types and constants of the spline waypoint path player
`default_nettype none
package swpp_pkg;
    localparam int MAX_WAYPOINTS = 16;
    localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
    localparam int POS_W = 32;
    localparam int ANG_W = 16;
    localparam int YAW_W = 17;
    localparam int DWELL_W = 24;
    localparam int DT_W = 16;
    localparam int TIME_W = 17;
    localparam int DLEFT_W = 25;
    localparam int H_W = 40;
    localparam int PROD_W = H_W + TIME_W + 1;
    localparam int YD_W = 18;
    localparam int APB_ADDR_W = 3;

    localparam logic [TIME_W-1:0] ONE_Q16 = TIME_W'(65536);
    localparam int HALF_TURN = 11520;
    localparam int FULL_TURN = 23040;

    localparam logic [APB_ADDR_W-1:0] ADDR_LOOP_ENABLE = APB_ADDR_W'(0);

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_TICK   = 3'd0;
    localparam t_kind KIND_APPEND = 3'd1;
    localparam t_kind KIND_CLEAR  = 3'd2;
    localparam t_kind KIND_PLAY   = 3'd3;
    localparam t_kind KIND_PAUSE  = 3'd4;
    localparam t_kind KIND_STOP   = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_MUL,
        S_ACC,
        S_FIN,
        S_ANG_MUL,
        S_ANG_ACC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_H,
        OP_YAW,
        OP_PITCH
    } t_opsel;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [ANG_W-1:0] yaw;
        logic signed [ANG_W-1:0] pitch;
        logic [DWELL_W-1:0]      dwell;
    } t_wp;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  wr_addr;
        logic              clr_pose;
        logic              rd_en;
        logic [1:0]        rd_slot;
        logic [IDX_W-1:0]  rd_addr;
        logic              load_d;
        logic              mul;
        t_opsel            op_sel;
        logic              acc;
        logic [1:0]        coef_sel;
        logic [1:0]        axis;
        logic              fin;
        logic              ang_acc;
        logic              load_out;
        logic [TIME_W-1:0] t;
    } t_dp_cmd;

    typedef struct packed {
        logic [DWELL_W-1:0] dwell_i2;
    } t_dp_stat;
endpackage
`default_nettype wire

// ===== hw/rtl/swpp_if.sv =====
// item channel interfaces of the spline waypoint path player
`default_nettype none
interface swpp_in_if;
    import swpp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [2:0]              kind;
    logic [DT_W-1:0]         dt;
    logic signed [POS_W-1:0] wp_x;
    logic signed [POS_W-1:0] wp_y;
    logic signed [POS_W-1:0] wp_z;
    logic signed [ANG_W-1:0] wp_yaw;
    logic signed [ANG_W-1:0] wp_pitch;
    logic [DWELL_W-1:0]      wp_dwell;
    modport source(output valid, kind, dt, wp_x, wp_y, wp_z, wp_yaw, wp_pitch, wp_dwell,
                   input ready);
    modport sink(input valid, kind, dt, wp_x, wp_y, wp_z, wp_yaw, wp_pitch, wp_dwell,
                 output ready);
endinterface

interface swpp_out_if;
    import swpp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [YAW_W-1:0] yaw_out;
    logic signed [ANG_W-1:0] pitch_out;
    logic                    pose_valid;
    logic                    in_progress;
    logic                    path_done;
    modport source(output valid, pos_x, pos_y, pos_z, yaw_out, pitch_out, pose_valid,
                   in_progress, path_done, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, yaw_out, pitch_out, pose_valid,
                 in_progress, path_done, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/swpp_datapath.sv =====
// waypoint memory, shared multiplier and horner accumulator
`default_nettype none
module swpp_datapath (
    input  logic                             i_clk,
    input  swpp_pkg::t_dp_cmd                i_cmd,
    input  swpp_pkg::t_wp                    i_wr_row,
    output swpp_pkg::t_dp_stat               o_stat,
    output logic signed [swpp_pkg::POS_W-1:0] o_pos_x,
    output logic signed [swpp_pkg::POS_W-1:0] o_pos_y,
    output logic signed [swpp_pkg::POS_W-1:0] o_pos_z,
    output logic signed [swpp_pkg::YAW_W-1:0] o_yaw,
    output logic signed [swpp_pkg::ANG_W-1:0] o_pitch
);
    import swpp_pkg::*;

    localparam logic signed [H_W-1:0] POS_MAX = H_W'(64'sd2147483647);
    localparam logic signed [H_W-1:0] POS_MIN = -POS_MAX - H_W'(1);
    localparam logic signed [YD_W-1:0] HALF_YD = YD_W'(HALF_TURN);
    localparam logic signed [YD_W-1:0] FULL_YD = YD_W'(FULL_TURN);

    t_wp r_mem [MAX_WAYPOINTS];
    t_wp r_row [4];

    logic signed [H_W-1:0]    r_h;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [POS_W-1:0]  r_pos [3];
    logic signed [YAW_W-1:0]  r_yaw;
    logic signed [ANG_W-1:0]  r_pitch;

    logic signed [H_W-1:0]    p0, p1, p2, p3;
    logic signed [H_W-1:0]    coef_d, coef, op_a, hf, sat;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [H_W-1:0]    rnd_h;
    logic signed [YD_W-1:0]   yd, pd;
    logic signed [ANG_W-1:0]  ya, pa;

    function automatic logic signed [POS_W-1:0] axis_pos(input t_wp w, input logic [1:0] a);
        logic signed [POS_W-1:0] v;
        case (a)
            2'd0:    v = w.x;
            2'd1:    v = w.y;
            default: v = w.z;
        endcase
        return v;
    endfunction

    always_comb begin
        p0 = H_W'($signed(axis_pos(r_row[0], i_cmd.axis)));
        p1 = H_W'($signed(axis_pos(r_row[1], i_cmd.axis)));
        p2 = H_W'($signed(axis_pos(r_row[2], i_cmd.axis)));
        p3 = H_W'($signed(axis_pos(r_row[3], i_cmd.axis)));
        coef_d = -p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3;
        case (i_cmd.coef_sel)
            2'd0:    coef = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
            2'd1:    coef = p2 - p0;
            default: coef = p1 <<< 1;
        endcase
    end

    always_comb begin
        ya = $signed(r_row[1].yaw);
        pa = $signed(r_row[1].pitch);
        yd = YD_W'($signed(r_row[2].yaw)) - YD_W'(ya);
        for (int k = 0; k < 3; k++) begin
            if (yd > HALF_YD) begin
                yd = yd - FULL_YD;
            end else if (yd < -HALF_YD) begin
                yd = yd + FULL_YD;
            end
        end
        pd = YD_W'($signed(r_row[2].pitch)) - YD_W'(pa);
        case (i_cmd.op_sel)
            OP_YAW:   op_a = H_W'(yd);
            OP_PITCH: op_a = H_W'(pd);
            default:  op_a = r_h;
        endcase
    end

    assign prod_rnd = (r_prod + PROD_W'(32768)) >>> 16;
    assign rnd_h    = prod_rnd[H_W-1:0];

    always_comb begin
        hf = (r_h + H_W'(1)) >>> 1;
        if (hf > POS_MAX) begin
            sat = POS_MAX;
        end else if (hf < POS_MIN) begin
            sat = POS_MIN;
        end else begin
            sat = hf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.wr_addr] <= i_wr_row;
        end
        if (i_cmd.rd_en) begin
            r_row[i_cmd.rd_slot] <= r_mem[i_cmd.rd_addr];
        end
        if (i_cmd.mul) begin
            r_prod <= op_a * $signed({1'b0, i_cmd.t});
        end
        if (i_cmd.load_d) begin
            r_h <= coef_d;
        end else if (i_cmd.acc) begin
            r_h <= rnd_h + coef;
        end
        if (i_cmd.clr_pose) begin
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
            r_yaw    <= '0;
            r_pitch  <= '0;
        end else begin
            if (i_cmd.fin) begin
                r_pos[i_cmd.axis] <= sat[POS_W-1:0];
            end
            if (i_cmd.ang_acc && i_cmd.op_sel == OP_YAW) begin
                r_yaw <= YAW_W'(ya) + rnd_h[YAW_W-1:0];
            end
            if (i_cmd.ang_acc && i_cmd.op_sel == OP_PITCH) begin
                r_pitch <= pa + rnd_h[ANG_W-1:0];
            end
        end
        if (i_cmd.load_out) begin
            o_pos_x <= r_pos[0];
            o_pos_y <= r_pos[1];
            o_pos_z <= r_pos[2];
            o_yaw   <= r_yaw;
            o_pitch <= r_pitch;
        end
    end

    assign o_stat.dwell_i2 = r_row[2].dwell;
endmodule
`default_nettype wire

// ===== hw/rtl/swpp_ctrl.sv =====
// path state, item decode and evaluation sequencer
`default_nettype none
`include "spline_waypoint_path_player_top_defines.svh"
module swpp_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_kind,
    input  logic [swpp_pkg::DT_W-1:0]  i_dt,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_pose_valid,
    output logic                       o_in_progress,
    output logic                       o_path_done,
    input  logic                       i_loop_enable,
    input  swpp_pkg::t_dp_stat         i_stat,
    output swpp_pkg::t_dp_cmd          o_cmd
);
    import swpp_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_seg, n_seg;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [DLEFT_W-1:0] r_dleft, n_dleft;
    logic r_playing, n_playing, r_paused, n_paused;
    logic r_finished, n_finished, r_dwell, n_dwell;
    logic r_res_valid, n_res_valid, r_res_prog, n_res_prog;
    logic r_ovalid, n_ovalid, r_opv, r_oprog, r_odone;
    logic [1:0] r_cnt, n_cnt, r_axis, n_axis;
    logic r_ang, n_ang;

    logic in_acc, go_calc, out_load, active;
    logic [CNT_W-1:0] seg_c, seg_a, i1, i2, i0, i3;
    logic [IDX_W-1:0] idx [4];
    logic [TIME_W:0]  tsum;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_out_ready);
    assign active   = r_playing && !r_paused && !r_finished && (r_count >= CNT_W'(2));
    assign seg_c    = CNT_W'(r_seg);
    assign seg_a    = r_dwell ? seg_c + CNT_W'(1) : seg_c;

    always_comb begin
        i1 = (seg_c > r_count - CNT_W'(2)) ? r_count - CNT_W'(2) : seg_c;
        i2 = i1 + CNT_W'(1);
        i0 = (i1 > '0) ? i1 - CNT_W'(1) : i1;
        i3 = (i2 + CNT_W'(1) < r_count) ? i2 + CNT_W'(1) : r_count - CNT_W'(1);
        idx[0] = i0[IDX_W-1:0];
        idx[1] = i1[IDX_W-1:0];
        idx[2] = i2[IDX_W-1:0];
        idx[3] = i3[IDX_W-1:0];
    end

    // path state update
    always_comb begin
        n_count     = r_count;
        n_seg       = r_seg;
        n_time      = r_time;
        n_dleft     = r_dleft;
        n_playing   = r_playing;
        n_paused    = r_paused;
        n_finished  = r_finished;
        n_dwell     = r_dwell;
        n_res_valid = r_res_valid;
        n_res_prog  = r_res_prog;
        go_calc     = 1'b0;
        tsum        = '0;
        if (in_acc) begin
            n_res_valid = 1'b0;
            n_res_prog  = 1'b0;
            unique case (i_kind) inside
                KIND_TICK: begin
                    if (active) begin
                        if ((seg_c + CNT_W'(1) >= r_count) && !r_dwell) begin
                            n_res_prog = 1'b1;
                        end else if (r_dwell && r_dleft > DLEFT_W'(i_dt)) begin
                            n_dleft    = r_dleft - DLEFT_W'(i_dt);
                            n_res_prog = 1'b1;
                        end else if (r_dwell && (seg_a + CNT_W'(1) >= r_count)
                                     && !i_loop_enable) begin
                            n_dleft    = '0;
                            n_dwell    = 1'b0;
                            n_seg      = seg_a[IDX_W-1:0];
                            n_time     = '0;
                            n_finished = 1'b1;
                            n_playing  = 1'b0;
                        end else begin
                            if (r_dwell) begin
                                n_dleft = '0;
                                n_dwell = 1'b0;
                                n_seg   = (seg_a + CNT_W'(1) >= r_count) ? '0
                                                                         : seg_a[IDX_W-1:0];
                            end
                            tsum = (r_dwell ? '0 : {1'b0, r_time}) + (TIME_W + 1)'(i_dt);
                            n_time      = (tsum > {1'b0, ONE_Q16}) ? ONE_Q16 : tsum[TIME_W-1:0];
                            n_res_valid = 1'b1;
                            n_res_prog  = 1'b1;
                            go_calc     = 1'b1;
                        end
                    end
                end
                KIND_APPEND: begin
                    if (r_count < CNT_W'(MAX_WAYPOINTS)) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                KIND_CLEAR, KIND_STOP, KIND_PLAY: begin
                    if (i_kind != KIND_PLAY || r_count >= CNT_W'(2)) begin
                        n_seg      = '0;
                        n_time     = '0;
                        n_dleft    = '0;
                        n_paused   = 1'b0;
                        n_finished = 1'b0;
                        n_dwell    = 1'b0;
                        n_playing  = (i_kind == KIND_PLAY);
                    end
                    if (i_kind == KIND_CLEAR) begin
                        n_count = '0;
                    end
                end
                KIND_PAUSE: begin
                    n_paused = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_ANG_ACC && r_ang && r_time == ONE_Q16) begin
            n_dwell = 1'b1;
            n_dleft = DLEFT_W'(i_stat.dwell_i2);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        n_ang   = r_ang;
        unique case (r_state)
            S_IDLE: begin
                n_cnt  = '0;
                n_axis = '0;
                n_ang  = 1'b0;
                if (in_acc) begin
                    n_state = go_calc ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC: begin
                n_cnt   = r_cnt + 2'd1;
                n_state = (r_cnt == 2'd2) ? S_FIN : S_MUL;
            end
            S_FIN: begin
                n_cnt   = '0;
                n_axis  = r_axis + 2'd1;
                n_state = (r_axis == 2'd2) ? S_ANG_MUL : S_LOAD;
            end
            S_ANG_MUL: n_state = S_ANG_ACC;
            S_ANG_ACC: begin
                n_ang   = 1'b1;
                n_state = r_ang ? S_DONE : S_ANG_MUL;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.op_sel   = OP_H;
        o_cmd.t        = r_time;
        o_cmd.axis     = r_axis;
        o_cmd.coef_sel = r_cnt;
        o_cmd.wr_addr  = r_count[IDX_W-1:0];
        o_cmd.rd_slot  = r_cnt;
        o_cmd.rd_addr  = idx[r_cnt];
        unique case (r_state)
            S_IDLE: begin
                o_cmd.clr_pose = in_acc;
                o_cmd.we = in_acc && (i_kind == KIND_APPEND)
                           && (r_count < CNT_W'(MAX_WAYPOINTS));
            end
            S_READ:    o_cmd.rd_en = 1'b1;
            S_LOAD:    o_cmd.load_d = 1'b1;
            S_MUL:     o_cmd.mul = 1'b1;
            S_ACC:     o_cmd.acc = 1'b1;
            S_FIN:     o_cmd.fin = 1'b1;
            S_ANG_MUL: begin
                o_cmd.mul    = 1'b1;
                o_cmd.op_sel = r_ang ? OP_PITCH : OP_YAW;
            end
            S_ANG_ACC: begin
                o_cmd.ang_acc = 1'b1;
                o_cmd.op_sel  = r_ang ? OP_PITCH : OP_YAW;
            end
            S_DONE:    o_cmd.load_out = out_load;
            default: begin
            end
        endcase
    end

    assign n_ovalid = out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_seg       <= '0;
            r_time      <= '0;
            r_dleft     <= '0;
            r_playing   <= 1'b0;
            r_paused    <= 1'b0;
            r_finished  <= 1'b0;
            r_dwell     <= 1'b0;
            r_res_valid <= 1'b0;
            r_res_prog  <= 1'b0;
            r_ovalid    <= 1'b0;
            r_cnt       <= '0;
            r_axis      <= '0;
            r_ang       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_seg       <= n_seg;
            r_time      <= n_time;
            r_dleft     <= n_dleft;
            r_playing   <= n_playing;
            r_paused    <= n_paused;
            r_finished  <= n_finished;
            r_dwell     <= n_dwell;
            r_res_valid <= n_res_valid;
            r_res_prog  <= n_res_prog;
            r_ovalid    <= n_ovalid;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_ang       <= n_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_opv   <= r_res_valid;
            r_oprog <= r_res_prog;
            r_odone <= r_finished;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_pose_valid  = r_opv;
    assign o_in_progress = r_oprog;
    assign o_path_done   = r_odone;

    `SWPP_ASSERT_IMP(a_play_fin_excl, r_playing, !r_finished, "playing and finished together")
    `SWPP_ASSERT_IMP(a_dwell_playing, r_dwell, r_playing, "dwelling while not playing")
    `SWPP_ASSERT_IMP(a_time_range, 1'b1, r_time <= ONE_Q16, "segment time above one")
    `SWPP_ASSERT_IMP(a_calc_count, (r_state != S_IDLE) && (r_state != S_DONE),
                     r_count >= CNT_W'(2), "evaluating with too few waypoints")
    `SWPP_ASSERT_NXT(a_calc_start, in_acc && go_calc, r_state == S_READ && r_res_valid,
                     "pose evaluation not started")
endmodule
`default_nettype wire

// ===== hw/rtl/spline_waypoint_path_player_top.sv =====
// top level of the spline waypoint path player
//
// channel   dir   handshake       payload
// i_in      in    valid/ready     kind dt wp_x wp_y wp_z wp_yaw wp_pitch wp_dwell
// o_out     out   valid/ready     pos_x pos_y pos_z yaw_out pitch_out flags
// apb       in    psel/penable    loop_enable at byte address 0
//
// a pose tick, once accepted, reads the four neighbouring waypoints, then evaluates each axis
// on the shared 40x18 multiplier, then yaw and pitch; other items go straight to the result
// one item at a time; the next item is taken while a result waits in the output register
// synchronous active-low reset clears the path state, the table reads empty
`default_nettype none
module spline_waypoint_path_player_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    swpp_in_if.sink                         i_in,
    swpp_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swpp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import swpp_pkg::*;

    logic     r_loop_enable;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_wp      wr_row;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_enable <= 1'b0;
        end else if (psel && penable && pwrite && paddr == ADDR_LOOP_ENABLE) begin
            r_loop_enable <= pwdata[0];
        end
    end

    assign prdata = (paddr == ADDR_LOOP_ENABLE) ? {31'b0, r_loop_enable} : 32'b0;

    assign wr_row.x     = i_in.wp_x;
    assign wr_row.y     = i_in.wp_y;
    assign wr_row.z     = i_in.wp_z;
    assign wr_row.yaw   = i_in.wp_yaw;
    assign wr_row.pitch = i_in.wp_pitch;
    assign wr_row.dwell = i_in.wp_dwell;

    swpp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_kind        (i_in.kind),
        .i_dt          (i_in.dt),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_pose_valid  (o_out.pose_valid),
        .o_in_progress (o_out.in_progress),
        .o_path_done   (o_out.path_done),
        .i_loop_enable (r_loop_enable),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    swpp_datapath u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_wr_row (wr_row),
        .o_stat   (stat),
        .o_pos_x  (o_out.pos_x),
        .o_pos_y  (o_out.pos_y),
        .o_pos_z  (o_out.pos_z),
        .o_yaw    (o_out.yaw_out),
        .o_pitch  (o_out.pitch_out)
    );
endmodule
`default_nettype wire
